// ===== src/bitmap_font_text_renderer_macros.svh =====
`ifndef BITMAP_FONT_TEXT_RENDERER_MACROS_SVH
`define BITMAP_FONT_TEXT_RENDERER_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define BFTR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bftr: same-cycle check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define BFTR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bftr: next-cycle check failed");

`endif

// ===== src/bftr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bftr_pkg;

  localparam int GLYPH_COUNT    = 256;
  localparam int MAX_GLYPH_ROWS = 32;

  localparam int CODE_W  = 8;
  localparam int GROW_W  = 5;
  localparam int PAT_W   = 32;
  localparam int ADDR_W  = 30;
  localparam int CUR_W   = 16;
  localparam int SCR_W   = 13;
  localparam int PITCH_W = 14;
  localparam int FONT_W  = 6;
  localparam int CFG_W   = 14;
  localparam int CIDX_W  = 3;

  localparam int STORE_DEPTH = GLYPH_COUNT * MAX_GLYPH_ROWS;
  localparam int STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int ROW_W       = (MAX_GLYPH_ROWS > 1) ? $clog2(MAX_GLYPH_ROWS) : 1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CUR_W-1:0]  CUR_MAX      = '1;
  localparam logic [CODE_W-1:0] NEWLINE_CODE = CODE_W'(10);

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_PRINT = 1'b1
  } cmd_e;

  typedef enum logic [CIDX_W-1:0] {
    CFG_SCREEN_WIDTH  = 3'd0,
    CFG_SCREEN_HEIGHT = 3'd1,
    CFG_PITCH_WORDS   = 3'd2,
    CFG_FONT_WIDTH    = 3'd3,
    CFG_FONT_HEIGHT   = 3'd4
  } cfg_idx_e;

  // Effective settings: font sizes already clamped.
  typedef struct packed {
    logic [SCR_W-1:0]   sw;
    logic [SCR_W-1:0]   sh;
    logic [PITCH_W-1:0] pitch;
    logic [FONT_W-1:0]  fw;
    logic [FONT_W-1:0]  fh;
  } cfg_t;

  typedef struct packed {
    logic              is_load;
    logic [CODE_W-1:0] code;
    logic [GROW_W-1:0] grow;
    logic [PAT_W-1:0]  pattern;
    logic [CUR_W-1:0]  col;
    logic [CUR_W-1:0]  row;
  } job_t;

  function automatic logic [PAT_W-1:0] low_mask(input logic [FONT_W-1:0] n);
    if (n >= FONT_W'(PAT_W)) begin
      return '1;
    end
    return (PAT_W'(1) << n) - PAT_W'(1);
  endfunction

  function automatic logic [CUR_W-1:0] sat_add(input logic [CUR_W-1:0] a,
                                               input logic [FONT_W-1:0] b);
    logic [CUR_W:0] s;
    s = {1'b0, a} + (CUR_W+1)'(b);
    return s[CUR_W] ? CUR_MAX : s[CUR_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== src/bftr_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface bftr_req_if;
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic [bftr_pkg::CODE_W-1:0]  char_code;
  logic [bftr_pkg::GROW_W-1:0]  glyph_row;
  logic [bftr_pkg::PAT_W-1:0]   row_pattern;

  modport source (output valid, cmd, char_code, glyph_row, row_pattern, input ready);
  modport sink   (input valid, cmd, char_code, glyph_row, row_pattern, output ready);
endinterface

`default_nettype wire

// ===== src/bftr_res_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface bftr_res_if;
  logic                         valid;
  logic                         ready;
  logic [bftr_pkg::ADDR_W-1:0]  row_address;
  logic [bftr_pkg::PAT_W-1:0]   row_pixels;
  logic [bftr_pkg::PAT_W-1:0]   row_enable;
  logic                         last;

  modport source (output valid, row_address, row_pixels, row_enable, last, input ready);
  modport sink   (input valid, row_address, row_pixels, row_enable, last, output ready);
endinterface

`default_nettype wire

// ===== src/bftr_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bftr_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  bftr_req_if.sink            req,
  input  wire bftr_pkg::cfg_t cfg_i,
  input  wire logic           full_i,
  output logic                push_o,
  output bftr_pkg::job_t      job_o
);

  logic [bftr_pkg::CUR_W-1:0] col_q, col_d;
  logic [bftr_pkg::CUR_W-1:0] row_q, row_d;
  logic [bftr_pkg::CUR_W-1:0] col_adv, row_wrap;
  logic [bftr_pkg::CUR_W:0]   col_end, row_end;
  logic                       wrap, home, acc;

  assign req.ready = !full_i;
  assign acc       = req.valid && !full_i;

  assign job_o.is_load = (req.cmd == bftr_pkg::CMD_LOAD);
  assign job_o.code    = req.char_code;
  assign job_o.grow    = req.glyph_row;
  assign job_o.pattern = req.row_pattern;
  assign job_o.col     = col_q;
  assign job_o.row     = row_q;

  always_comb begin
    col_adv  = bftr_pkg::sat_add(col_q, cfg_i.fw);
    col_end  = {1'b0, col_adv} + (bftr_pkg::CUR_W+1)'(cfg_i.fw);
    wrap     = col_end > (bftr_pkg::CUR_W+1)'(cfg_i.sw);
    row_wrap = wrap ? bftr_pkg::sat_add(row_q, cfg_i.fh) : row_q;
    row_end  = {1'b0, row_wrap} + (bftr_pkg::CUR_W+1)'(cfg_i.fh);
    home     = row_end > (bftr_pkg::CUR_W+1)'(cfg_i.sh);
    col_d    = col_q;
    row_d    = row_q;
    push_o   = 1'b0;
    if (acc) begin
      if (req.cmd == bftr_pkg::CMD_LOAD) begin
        push_o = 1'b1;
      end else if (req.char_code == bftr_pkg::NEWLINE_CODE) begin
        col_d = '0;
        row_d = bftr_pkg::sat_add(row_q, cfg_i.fh);
      end else begin
        push_o = 1'b1;
        if (home) begin
          col_d = '0;
          row_d = '0;
        end else begin
          col_d = wrap ? '0 : col_adv;
          row_d = row_wrap;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/bftr_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "bitmap_font_text_renderer_macros.svh"

module bftr_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire bftr_pkg::job_t job_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                valid_o,
  output bftr_pkg::job_t      job_o
);

  bftr_pkg::job_t              slot_q [bftr_pkg::QUEUE_DEPTH];
  logic [bftr_pkg::QPTR_W-1:0] wptr_q, rptr_q;
  logic [bftr_pkg::QCNT_W-1:0] count_q;

  assign full_o  = (count_q == bftr_pkg::QCNT_W'(bftr_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign job_o   = slot_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == bftr_pkg::QPTR_W'(bftr_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                            : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == bftr_pkg::QPTR_W'(bftr_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                            : rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  `BFTR_ASSERT_NEXT(a_count_grows, push_i && !pop_i, count_q == bftr_pkg::QCNT_W'($past(count_q) + 1'b1))
  `BFTR_ASSERT_IMPL(a_no_pop_empty, pop_i, valid_o)

endmodule

`default_nettype wire

// ===== src/bftr_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "bitmap_font_text_renderer_macros.svh"

module bftr_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire bftr_pkg::cfg_t cfg_i,
  input  wire logic           valid_i,
  input  wire bftr_pkg::job_t job_i,
  output logic                pop_o,
  bftr_res_if.source          res
);

  typedef enum logic [1:0] {
    BK_IDLE = 2'b01,
    BK_DRAW = 2'b10
  } back_state_e;

  back_state_e state_q, state_d;

  logic [bftr_pkg::PAT_W-1:0]  store [bftr_pkg::STORE_DEPTH];

  logic [bftr_pkg::ROW_W-1:0]  row_q;
  logic [bftr_pkg::CODE_W-1:0] code_q;
  logic [bftr_pkg::CUR_W-1:0]  col_q, crow_q;
  logic                        blank_q;

  logic                        s1_valid_q;
  logic [bftr_pkg::PAT_W-1:0]  s1_data_q;
  logic [bftr_pkg::CUR_W+bftr_pkg::PITCH_W:0] s1_prod_q;
  logic [bftr_pkg::PAT_W-1:0]  s1_en_q;
  logic [bftr_pkg::CUR_W-1:0]  s1_col_q;
  logic                        s1_blank_q, s1_last_q;

  logic                        out_valid_q;
  logic [bftr_pkg::ADDR_W-1:0] out_addr_q;
  logic [bftr_pkg::PAT_W-1:0]  out_pix_q, out_en_q;
  logic                        out_last_q;

  logic                        s1_adv, issue, last_row, st_we;
  logic [bftr_pkg::STORE_AW-1:0] st_waddr, st_raddr;
  logic [bftr_pkg::CUR_W:0]    y;
  logic [bftr_pkg::SCR_W-1:0]  room;
  logic [bftr_pkg::FONT_W-1:0] span;
  logic [bftr_pkg::PAT_W-1:0]  wmask, en;

  assign wmask    = bftr_pkg::low_mask(cfg_i.fw);
  assign s1_adv   = s1_valid_q && (!out_valid_q || res.ready);
  assign issue    = (state_q == BK_DRAW) && (!s1_valid_q || s1_adv);
  assign last_row = (bftr_pkg::FONT_W'(row_q) == cfg_i.fh - 1'b1);
  assign pop_o    = (state_q == BK_IDLE) && valid_i;

  assign st_we    = pop_o && job_i.is_load
                    && ((bftr_pkg::CODE_W+1)'(job_i.code) < (bftr_pkg::CODE_W+1)'(bftr_pkg::GLYPH_COUNT))
                    && ((bftr_pkg::GROW_W+1)'(job_i.grow) < (bftr_pkg::GROW_W+1)'(bftr_pkg::MAX_GLYPH_ROWS));
  assign st_waddr = bftr_pkg::STORE_AW'(32'(job_i.code) * bftr_pkg::MAX_GLYPH_ROWS
                                        + 32'(job_i.grow));
  assign st_raddr = bftr_pkg::STORE_AW'(32'(code_q) * bftr_pkg::MAX_GLYPH_ROWS + 32'(row_q));

  always_comb begin
    y    = {1'b0, crow_q} + (bftr_pkg::CUR_W+1)'(row_q);
    room = cfg_i.sw - col_q[bftr_pkg::SCR_W-1:0];
    span = (room < bftr_pkg::SCR_W'(cfg_i.fw)) ? room[bftr_pkg::FONT_W-1:0] : cfg_i.fw;
    en   = '0;
    if ((y < (bftr_pkg::CUR_W+1)'(cfg_i.sh)) && (col_q < bftr_pkg::CUR_W'(cfg_i.sw))) begin
      en = bftr_pkg::low_mask(span) & wmask;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (pop_o && !job_i.is_load) begin
          state_d = BK_DRAW;
        end
      end
      BK_DRAW: begin
        if (issue && last_row) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      row_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop_o) begin
        row_q <= '0;
      end else if (issue) begin
        row_q <= row_q + 1'b1;
      end
      if (issue) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (res.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      store[st_waddr] <= job_i.pattern;
    end
    if (issue) begin
      s1_data_q <= store[st_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && !job_i.is_load) begin
      code_q  <= job_i.code;
      col_q   <= job_i.col;
      crow_q  <= job_i.row;
      blank_q <= (bftr_pkg::CODE_W+1)'(job_i.code)
                 >= (bftr_pkg::CODE_W+1)'(bftr_pkg::GLYPH_COUNT);
    end
    if (issue) begin
      s1_prod_q  <= y * cfg_i.pitch;
      s1_en_q    <= en;
      s1_col_q   <= col_q;
      s1_blank_q <= blank_q;
      s1_last_q  <= last_row;
    end
    if (s1_adv) begin
      out_addr_q <= bftr_pkg::ADDR_W'(32'(s1_prod_q) + 32'(s1_col_q));
      out_pix_q  <= s1_blank_q ? '0 : (s1_data_q & wmask);
      out_en_q   <= s1_en_q;
      out_last_q <= s1_last_q;
    end
  end

  assign res.valid       = out_valid_q;
  assign res.row_address = out_addr_q;
  assign res.row_pixels  = out_pix_q;
  assign res.row_enable  = out_en_q;
  assign res.last        = out_last_q;

  `BFTR_ASSERT_IMPL(a_row_in_glyph, state_q == BK_DRAW, bftr_pkg::FONT_W'(row_q) < cfg_i.fh)
  `BFTR_ASSERT_NEXT(a_draw_ends, issue && last_row, state_q == BK_IDLE)
  `BFTR_ASSERT_NEXT(a_s1_holds, s1_valid_q && !s1_adv, s1_valid_q)

endmodule

`default_nettype wire

// ===== src/bitmap_font_text_renderer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Handshake      Payload
// req_i     in   valid/ready    cmd, char_code, glyph_row, row_pattern
// res_o     out  valid/ready    row_address, row_pixels, row_enable, last
// cfg       in   cfg_we_i       cfg_idx_i, cfg_data_i (write only)
//
// In the draw engine a printed glyph is first taken from the queue, then each of its
// rows takes one glyph store read and one address multiply, as the row pipeline allows.
// A load is written to the glyph store as it is taken; a newline is handled at the front.
// A four-entry job queue lets the front take requests while rows drain.
// Reset clears the cursor, queue and pipeline; glyph store contents are not reset.
// A stalled result holds the row pipeline; the front stalls only on a full queue.

module bitmap_font_text_renderer (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  bftr_req_if.sink                           req_i,
  bftr_res_if.source                         res_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [bftr_pkg::CIDX_W-1:0]   cfg_idx_i,
  input  wire logic [bftr_pkg::CFG_W-1:0]    cfg_data_i
);

  logic [bftr_pkg::SCR_W-1:0]   sw_q, sh_q;
  logic [bftr_pkg::PITCH_W-1:0] pitch_q;
  logic [bftr_pkg::FONT_W-1:0]  fw_q, fh_q;

  bftr_pkg::cfg_t cfg;
  bftr_pkg::job_t front_job, head_job;
  logic           push, full, head_valid, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q    <= bftr_pkg::SCR_W'(640);
      sh_q    <= bftr_pkg::SCR_W'(480);
      pitch_q <= bftr_pkg::PITCH_W'(640);
      fw_q    <= bftr_pkg::FONT_W'(8);
      fh_q    <= bftr_pkg::FONT_W'(16);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bftr_pkg::CFG_SCREEN_WIDTH:  sw_q    <= cfg_data_i[bftr_pkg::SCR_W-1:0];
        bftr_pkg::CFG_SCREEN_HEIGHT: sh_q    <= cfg_data_i[bftr_pkg::SCR_W-1:0];
        bftr_pkg::CFG_PITCH_WORDS:   pitch_q <= cfg_data_i[bftr_pkg::PITCH_W-1:0];
        bftr_pkg::CFG_FONT_WIDTH:    fw_q    <= cfg_data_i[bftr_pkg::FONT_W-1:0];
        bftr_pkg::CFG_FONT_HEIGHT:   fh_q    <= cfg_data_i[bftr_pkg::FONT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.sw    = sw_q;
    cfg.sh    = sh_q;
    cfg.pitch = pitch_q;
    if (fw_q == '0) begin
      cfg.fw = bftr_pkg::FONT_W'(1);
    end else if (fw_q > bftr_pkg::FONT_W'(bftr_pkg::PAT_W)) begin
      cfg.fw = bftr_pkg::FONT_W'(bftr_pkg::PAT_W);
    end else begin
      cfg.fw = fw_q;
    end
    if (fh_q == '0) begin
      cfg.fh = bftr_pkg::FONT_W'(1);
    end else if (fh_q > bftr_pkg::FONT_W'(bftr_pkg::MAX_GLYPH_ROWS)) begin
      cfg.fh = bftr_pkg::FONT_W'(bftr_pkg::MAX_GLYPH_ROWS);
    end else begin
      cfg.fh = fh_q;
    end
  end

  bftr_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req_i),
    .cfg_i  (cfg),
    .full_i (full),
    .push_o (push),
    .job_o  (front_job)
  );

  bftr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (front_job),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .job_o   (head_job)
  );

  bftr_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (head_valid),
    .job_i   (head_job),
    .pop_o   (pop),
    .res     (res_o)
  );

endmodule

`default_nettype wire
